### rtl/eca_pkg.sv
// Shared types and codes for the elementary cellular row stepper.
`default_nettype none
package eca_pkg;

    // Operation carried by an input word.
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // Status returned with every result word.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOTTOM = 2'd1,
        ST_NO_ROW = 2'd2
    } t_status;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RULE  = 2'd0;
    localparam logic [1:0] CFG_WRAP  = 2'd1;
    localparam logic [1:0] CFG_WIDTH = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    localparam int unsigned RULE_W   = 8;
    localparam int unsigned WIDTH_W  = 7;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned INDEX_W  = 12;
    localparam int unsigned CELLS_W  = 64;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned INDEX_LIMIT = 4096;

    // Neighborhood of one cell; the bit order matches the rule table index.
    typedef struct packed {
        logic right;
        logic self;
        logic left;
    } t_nbhd;

endpackage
`default_nettype wire

### rtl/elementary_ca_row_step.sv
// A result word is registered and appears in the cycle after its input word is accepted.
// One word per cycle while the result side keeps up; all cell lanes evaluate a row in parallel.
// The input takes a new word while the result register is empty or being read.
// Reset (synchronous, active low) clears the row, its index and the selection,
// and sets rule 0, plain edges, width 64 and count 64.
`default_nettype none
module elementary_ca_row_step #(
    parameter int unsigned MAX_COLS = 64,
    parameter int unsigned MAX_ROWS = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [eca_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_operation,
    input  wire logic [eca_pkg::CELLS_W-1:0]        i_row_cells,
    input  wire logic [eca_pkg::INDEX_W-1:0]        i_start_index,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [eca_pkg::CELLS_W-1:0]             o_result_cells,
    output logic [eca_pkg::INDEX_W-1:0]             o_result_index,
    output logic [1:0]                              o_status
);

    localparam int unsigned IdxW = $clog2(MAX_COLS);
    localparam int unsigned CountCap =
        (MAX_ROWS < eca_pkg::INDEX_LIMIT) ? MAX_ROWS : eca_pkg::INDEX_LIMIT;
    localparam logic [eca_pkg::WIDTH_W-1:0] ColCap = eca_pkg::WIDTH_W'(MAX_COLS);
    localparam logic [eca_pkg::COUNT_W-1:0] RowCap = eca_pkg::COUNT_W'(CountCap);

    // Configuration registers.
    logic [eca_pkg::RULE_W-1:0]  r_rule;
    logic                        r_wrap;
    logic [eca_pkg::WIDTH_W-1:0] r_row_width;
    logic [eca_pkg::COUNT_W-1:0] r_row_count;

    // Row state and result register.
    logic [MAX_COLS-1:0]         r_cells, n_cells;
    logic [eca_pkg::INDEX_W-1:0] r_index, n_index;
    logic                        r_sel, n_sel;
    eca_pkg::t_status            r_status, n_status;
    logic                        r_out_valid, n_out_valid;

    logic                        accept;
    logic [eca_pkg::WIDTH_W-1:0] width_eff;
    logic [eca_pkg::WIDTH_W-1:0] width_m1;
    logic [IdxW-1:0]             last_col;
    logic [eca_pkg::COUNT_W-1:0] count_eff;
    logic [eca_pkg::COUNT_W-1:0] next_idx;
    logic                        at_bottom;
    logic [MAX_COLS-1:0]         col_mask;
    logic [MAX_COLS-1:0]         row_m;
    logic [MAX_COLS-1:0]         lane_cells;
    logic [MAX_COLS-1:0]         stepped;

    always_comb begin
        if (r_row_width == '0) begin
            width_eff = eca_pkg::WIDTH_W'(1);
        end else if (r_row_width > ColCap) begin
            width_eff = ColCap;
        end else begin
            width_eff = r_row_width;
        end
        if (r_row_count == '0) begin
            count_eff = eca_pkg::COUNT_W'(1);
        end else if (r_row_count > RowCap) begin
            count_eff = RowCap;
        end else begin
            count_eff = r_row_count;
        end
    end

    assign width_m1  = width_eff - eca_pkg::WIDTH_W'(1);
    assign last_col  = width_m1[IdxW-1:0];
    assign next_idx  = {1'b0, r_index} + eca_pkg::COUNT_W'(1);
    assign at_bottom = (next_idx >= count_eff);
    assign row_m     = r_cells & col_mask;

    // One lane per column; the edge lanes pick up the wrapped neighbors.
    for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
        eca_pkg::t_nbhd nbhd;
        logic           is_last;

        assign col_mask[c] = (IdxW'(c) <= last_col);
        assign is_last     = (IdxW'(c) == last_col);
        assign nbhd.self   = row_m[c];

        if (c == 0) begin : g_first
            assign nbhd.left = r_wrap & row_m[last_col];
        end else begin : g_mid_l
            assign nbhd.left = row_m[c-1];
        end

        if (c == MAX_COLS - 1) begin : g_end
            assign nbhd.right = r_wrap & is_last & row_m[0];
        end else begin : g_mid_r
            assign nbhd.right = row_m[c+1] | (r_wrap & is_last & row_m[0]);
        end

        eca_lane u_lane (
            .i_rule   (r_rule),
            .i_nbhd   (nbhd),
            .i_in_use (col_mask[c]),
            .o_cell   (lane_cells[c])
        );
    end

    // Merge: OR in the existing next-row cells and clear unused columns.
    assign stepped = (lane_cells | i_row_cells[MAX_COLS-1:0]) & col_mask;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_cells     = r_cells;
        n_index     = r_index;
        n_sel       = r_sel;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        if (accept) begin
            n_out_valid = 1'b1;
            unique case (eca_pkg::t_op'(i_operation))
                eca_pkg::OP_LOAD: begin
                    n_cells  = i_row_cells[MAX_COLS-1:0] & col_mask;
                    n_index  = i_start_index;
                    n_sel    = 1'b1;
                    n_status = eca_pkg::ST_OK;
                end
                eca_pkg::OP_STEP: begin
                    priority if (!r_sel) begin
                        n_status = eca_pkg::ST_NO_ROW;
                    end else if (at_bottom) begin
                        n_sel    = 1'b0;
                        n_status = eca_pkg::ST_BOTTOM;
                    end else begin
                        n_cells  = stepped;
                        n_index  = next_idx[eca_pkg::INDEX_W-1:0];
                        n_status = eca_pkg::ST_OK;
                    end
                end
                default: begin
                    n_status = r_status;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule      <= '0;
            r_wrap      <= 1'b0;
            r_row_width <= eca_pkg::WIDTH_W'(64);
            r_row_count <= eca_pkg::COUNT_W'(64);
            r_cells     <= '0;
            r_index     <= '0;
            r_sel       <= 1'b0;
            r_status    <= eca_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_cells     <= n_cells;
            r_index     <= n_index;
            r_sel       <= n_sel;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    eca_pkg::CFG_RULE:  r_rule      <= i_cfg_data[eca_pkg::RULE_W-1:0];
                    eca_pkg::CFG_WRAP:  r_wrap      <= i_cfg_data[0];
                    eca_pkg::CFG_WIDTH: r_row_width <= i_cfg_data[eca_pkg::WIDTH_W-1:0];
                    eca_pkg::CFG_COUNT: r_row_count <= i_cfg_data[eca_pkg::COUNT_W-1:0];
                    default:            r_rule      <= r_rule;
                endcase
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_cells = eca_pkg::CELLS_W'(r_cells);
    assign o_result_index = r_index;
    assign o_status       = r_status;

endmodule
`default_nettype wire

### rtl/eca_lane.sv
// One cell lane: rule table lookup for a single neighborhood.
`default_nettype none
module eca_lane (
    input  wire logic [eca_pkg::RULE_W-1:0] i_rule,
    input  wire eca_pkg::t_nbhd             i_nbhd,
    input  wire logic                       i_in_use,
    output logic                            o_cell
);

    logic [2:0] pattern;

    assign pattern = i_nbhd;
    // Cells past the row width never turn on.
    assign o_cell  = i_in_use & i_rule[pattern];

endmodule
`default_nettype wire

### rtl/eca_checker.sv
// Port-level assertions for the row stepper, bound to the top level.
`default_nettype none
module eca_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic                           i_operation,
    input wire logic [eca_pkg::INDEX_W-1:0]    i_start_index,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [eca_pkg::CELLS_W-1:0]    o_result_cells,
    input wire logic [eca_pkg::INDEX_W-1:0]    o_result_index,
    input wire logic [1:0]                     o_status
);

    // No result word is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result word holds its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_cells)
            && $stable(o_result_index) && $stable(o_status))
        else $error("stalled result changed");

    // An empty result register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // A load always succeeds and reports the index it was given.
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == eca_pkg::OP_LOAD)
        |=> o_out_valid && (o_status == eca_pkg::ST_OK)
            && (o_result_index == $past(i_start_index)))
        else $error("load result mismatch");

    // Status codes stay within the defined set.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == eca_pkg::ST_OK) || (o_status == eca_pkg::ST_BOTTOM)
            || (o_status == eca_pkg::ST_NO_ROW))
        else $error("undefined status code");

endmodule

bind elementary_ca_row_step eca_checker u_eca_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_operation    (i_operation),
    .i_start_index  (i_start_index),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_cells (o_result_cells),
    .o_result_index (o_result_index),
    .o_status       (o_status)
);
`default_nettype wire

### verif/elementary_ca_row_step_tb.sv
// Self-checking testbench for the elementary cellular row stepper.
`timescale 1ns / 1ps

module elementary_ca_row_step_tb;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned RANDOM_WORDS = 950;

    typedef struct {
        logic [eca_pkg::CELLS_W-1:0] cells;
        logic [eca_pkg::INDEX_W-1:0] index;
        eca_pkg::t_status            status;
    } t_row_expect;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [1:0]                     cfg_index = eca_pkg::CFG_RULE;
    logic [eca_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    eca_pkg::t_op                   operation = eca_pkg::OP_LOAD;
    logic [eca_pkg::CELLS_W-1:0]    row_cells = '0;
    logic [eca_pkg::INDEX_W-1:0]    start_index = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [eca_pkg::CELLS_W-1:0]    result_cells;
    logic [eca_pkg::INDEX_W-1:0]    result_index;
    logic [1:0]                     result_status;

    elementary_ca_row_step DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_operation    (operation),
        .i_row_cells    (row_cells),
        .i_start_index  (start_index),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_result_cells (result_cells),
        .o_result_index (result_index),
        .o_status       (result_status)
    );

    always #10 clk = ~clk;

    // Shadow copy of the block's registers and row state.
    logic [eca_pkg::RULE_W-1:0]   cfg_rule;
    logic                         cfg_wrap;
    logic [eca_pkg::WIDTH_W-1:0]  cfg_width;
    logic [eca_pkg::COUNT_W-1:0]  cfg_count;
    logic [eca_pkg::CELLS_W-1:0]  model_cells;
    logic [eca_pkg::INDEX_W-1:0]  model_index;
    logic                         model_selected;

    t_row_expect pending_rows[$];
    t_row_expect head_row;
    int          error_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(cfg_width);
        if (w < 1) w = 1;
        if (w > eca_pkg::CELLS_W) w = eca_pkg::CELLS_W;
        return w;
    endfunction

    function automatic int unsigned active_count();
        int unsigned n;
        n = 32'(cfg_count);
        if (n < 1) n = 1;
        if (n > eca_pkg::INDEX_LIMIT) n = eca_pkg::INDEX_LIMIT;
        return n;
    endfunction

    function automatic logic [eca_pkg::CELLS_W-1:0] cell_mask(input int unsigned w);
        if (w >= eca_pkg::CELLS_W) return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    // One generation: the rule bit is picked by {right, self, left}.
    function automatic logic [eca_pkg::CELLS_W-1:0] evolve_row(
        input logic [eca_pkg::CELLS_W-1:0] row,
        input int unsigned                 w
    );
        logic [eca_pkg::CELLS_W-1:0] nxt;
        logic                        l;
        logic                        r;
        logic [2:0]                  k;
        nxt = '0;
        row = row & cell_mask(w);
        for (int unsigned c = 0; c < w; c++) begin
            l = (c > 0) ? row[c-1] : (cfg_wrap & row[w-1]);
            r = (c + 1 < w) ? row[c+1] : (cfg_wrap & row[0]);
            k = {r, row[c], l};
            nxt[c] = cfg_rule[k];
        end
        return nxt & cell_mask(w);
    endfunction

    function automatic void predict_row(input eca_pkg::t_op op,
                                        input logic [eca_pkg::CELLS_W-1:0] cells,
                                        input logic [eca_pkg::INDEX_W-1:0] idx);
        t_row_expect                 e;
        int unsigned                 w;
        logic [eca_pkg::CELLS_W-1:0] m;
        w = active_width();
        m = cell_mask(w);
        if (op == eca_pkg::OP_LOAD) begin
            model_cells = cells & m;
            model_index = idx;
            model_selected = 1'b1;
            e.status = eca_pkg::ST_OK;
        end else if (!model_selected) begin
            e.status = eca_pkg::ST_NO_ROW;
        end else if (int'(model_index) + 1 >= int'(active_count())) begin
            model_selected = 1'b0;
            e.status = eca_pkg::ST_BOTTOM;
        end else begin
            model_cells = (evolve_row(model_cells, w) | cells) & m;
            model_index = model_index + 1'b1;
            e.status = eca_pkg::ST_OK;
        end
        e.cells = model_cells;
        e.index = model_index;
        pending_rows.push_back(e);
    endfunction

    function automatic logic [eca_pkg::CELLS_W-1:0] random_fill();
        case ($urandom_range(0, 3))
            0, 1: return '0;
            2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word from a falling edge and hold it until it is taken.
    task automatic send_word(input eca_pkg::t_op op,
                             input logic [eca_pkg::CELLS_W-1:0] cells,
                             input logic [eca_pkg::INDEX_W-1:0] idx);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        row_cells <= cells;
        start_index <= idx;
        do @(posedge clk); while (!in_ready);
        predict_row(op, cells, idx);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes all four registers on consecutive cycles; junk sits above each field narrower than the data word.
    task automatic set_config(input int rule, input int wrap, input int width, input int count);
        int                             vals[4];
        int                             widths[4];
        logic [eca_pkg::CFG_DATA_W-1:0] d;
        logic [eca_pkg::CFG_DATA_W-1:0] m;
        vals = '{rule, wrap, width, count};
        widths = '{eca_pkg::RULE_W, 1, eca_pkg::WIDTH_W, eca_pkg::COUNT_W};
        drain();
        for (int i = 0; i < 4; i++) begin
            @(negedge clk);
            m = (eca_pkg::CFG_DATA_W'(1) << widths[i]) - 1'b1;
            if (widths[i] >= eca_pkg::CFG_DATA_W) m = '1;
            d = (eca_pkg::CFG_DATA_W'($urandom) & ~m) | (eca_pkg::CFG_DATA_W'(vals[i]) & m);
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= d;
            case (2'(i))
                eca_pkg::CFG_RULE:  cfg_rule = d[eca_pkg::RULE_W-1:0];
                eca_pkg::CFG_WRAP:  cfg_wrap = d[0];
                eca_pkg::CFG_WIDTH: cfg_width = d[eca_pkg::WIDTH_W-1:0];
                eca_pkg::CFG_COUNT: cfg_count = d[eca_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_idle_after_reset();
        // Reset settings: rule 0, plain edges, width 64, count 64.
        send_word(eca_pkg::OP_STEP, '1, 12'hFFF);
        send_word(eca_pkg::OP_LOAD, '1, 12'd0);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        send_word(eca_pkg::OP_STEP, '1, 12'd0);
    endtask

    task automatic test_edge_cases();
        // Zero width and zero count read as one.
        set_config(255, 1, 0, 0);
        send_word(eca_pkg::OP_LOAD, '1, 12'd0);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        // Oversized width and count saturate; walk onto the last index.
        set_config(30, 0, 100, 8191);
        send_word(eca_pkg::OP_LOAD, 64'h1 << 32, 12'd4094);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        send_word(eca_pkg::OP_LOAD, 64'h8000_0000_0000_0001, 12'd4095);
        send_word(eca_pkg::OP_STEP, '1, 12'd0);
        // Narrow cylinder; bits above the width must be dropped.
        set_config(90, 1, 3, 4096);
        send_word(eca_pkg::OP_LOAD, 64'hF0F0_0000_0000_0001, 12'd10);
        repeat (3) send_word(eca_pkg::OP_STEP, 64'hFFFF_0000_0000_0000, 12'd0);
        // Load past the bottom, then reload while a row is selected.
        set_config(110, 0, 64, 64);
        send_word(eca_pkg::OP_LOAD, '1, 12'd100);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        send_word(eca_pkg::OP_LOAD, 64'h8000_0000_0000_0000, 12'd5);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        send_word(eca_pkg::OP_LOAD, 64'h0000_0000_0001_0000, 12'd62);
        // Wrap across both ends of a full row.
        set_config(8'h96, 1, 64, 2);
        send_word(eca_pkg::OP_LOAD, 64'h8000_0000_0000_0001, 12'd0);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
        send_word(eca_pkg::OP_STEP, '0, 12'd0);
    endtask

    task automatic test_random_runs();
        int                          sent;
        int                          rule;
        int                          width;
        int                          count;
        int                          n;
        int                          hi;
        logic [eca_pkg::CELLS_W-1:0] cells;
        logic [eca_pkg::INDEX_W-1:0] start;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 7))
                0: rule = 0;
                1: rule = 255;
                default: rule = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 9))
                0: width = 0;
                1: width = 64;
                2: width = 1;
                3: width = $urandom_range(65, 127);
                default: width = $urandom_range(2, 64);
            endcase
            case ($urandom_range(0, 9))
                0: count = 0;
                1: count = 4096;
                2: count = $urandom_range(4097, 8191);
                3: count = 1;
                default: count = $urandom_range(2, 40);
            endcase
            set_config(rule, $urandom_range(0, 1), width, count);
            n = active_count();
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 5) == 0) start = eca_pkg::INDEX_W'($urandom);
                else if (n >= 4096) start = eca_pkg::INDEX_W'($urandom_range(4070, 4095));
                else begin
                    hi = (n + 1 > 4095) ? 4095 : n + 1;
                    start = eca_pkg::INDEX_W'($urandom_range(0, hi));
                end
                if ($urandom_range(0, 7) == 0) cells = 64'h1 << $urandom_range(0, 63);
                else cells = {$urandom, $urandom};
                // Now and then the load is left out, so steps run on the row left from before, selected or dropped.
                if ($urandom_range(0, 9) != 0) begin
                    send_word(eca_pkg::OP_LOAD, cells, start);
                    sent++;
                end
                repeat ($urandom_range(1, 24)) begin
                    send_word(eca_pkg::OP_STEP, random_fill(),
                              eca_pkg::INDEX_W'($urandom));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        set_config(30, 1, 64, 4096);
        hold_req = 1'b1;
        send_word(eca_pkg::OP_LOAD, 64'h1 << 20, 12'd7);
        repeat (39) send_word(eca_pkg::OP_STEP, random_fill(), 12'd0);
    endtask

    task automatic test_sender_pause();
        set_config(184, 0, 17, 30);
        send_word(eca_pkg::OP_LOAD, {$urandom, $urandom}, 12'd3);
        repeat (14) send_word(eca_pkg::OP_STEP, random_fill(), 12'd0);
        drain();
        repeat (15) send_word(eca_pkg::OP_STEP, random_fill(), 12'd0);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        set_config(54, 1, 48, 50);
        repeat (4) begin
            send_word(eca_pkg::OP_LOAD, {$urandom, $urandom},
                      eca_pkg::INDEX_W'($urandom_range(0, 30)));
            repeat (24) send_word(eca_pkg::OP_STEP, random_fill(), 12'd0);
        end
    endtask

    // Result side: random stalls, plus a long hold on request.
    initial begin
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected result word: cells %h index %0d status %0d",
                       result_cells, result_index, result_status);
                error_count++;
            end else begin
                head_row = pending_rows.pop_front();
                if (result_cells !== head_row.cells) begin
                    $error("result_cells: expected %h, actual %h", head_row.cells, result_cells);
                    error_count++;
                end
                if (result_index !== head_row.index) begin
                    $error("result_index: expected %0d, actual %0d", head_row.index,
                           result_index);
                    error_count++;
                end
                if (result_status !== head_row.status) begin
                    $error("status: expected %0d, actual %0d", head_row.status, result_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("elementary_ca_row_step_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_rule = '0;
        cfg_wrap = 1'b0;
        cfg_width = eca_pkg::WIDTH_W'(64);
        cfg_count = eca_pkg::COUNT_W'(64);
        model_cells = '0;
        model_index = '0;
        model_selected = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_idle_after_reset();
        test_edge_cases();
        test_random_runs();
        test_output_backpressure();
        test_sender_pause();
        test_steady_stream();
        drain();
        repeat (5) @(posedge clk);
        if (error_count == 0) begin
            $display("elementary_ca_row_step_tb: done, clean");
        end else begin
            $display("elementary_ca_row_step_tb: done, errors");
        end
        $finish;
    end

endmodule
